// ===== rtl/tic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_pkg
// Shared widths, payload layouts and request codes of the tuple id codec.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int unsigned REL_W     = 4;
  localparam int unsigned ARG_W     = 2;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned AR_W      = 3;

  localparam int unsigned RELATIONS = 16;
  localparam int unsigned MAX_ARITY = 4;
  localparam int unsigned SLOTS     = 64;

  localparam int unsigned HDR_AW    = REL_W + ARG_W;
  localparam int unsigned REC_AW    = HDR_AW + SLOT_W;
  localparam int unsigned REC_DW    = REL_W + 2 * ID_W;
  localparam int unsigned ARG_DW    = ID_W + CNT_W;
  localparam int unsigned RELH_DW   = AR_W + ID_W;

  localparam int unsigned IN_DW     = 128;
  localparam int unsigned OUT_DW    = 40;

  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  typedef enum logic [2:0] {
    REQ_REC = 3'd0,
    REQ_ARG = 3'd1,
    REQ_REL = 3'd2,
    REQ_ENC = 3'd3,
    REQ_DEC = 3'd4
  } req_e;

  typedef struct packed {
    logic [5:0]        pad;
    logic [AR_W-1:0]   arity;
    logic [CNT_W-1:0]  record_count;
    logic [ID_W-1:0]   domain_size;
    logic [ID_W-1:0]   index_base;
    logic [ID_W-1:0]   term_value;
    logic [REL_W-1:0]  term_relation;
    logic [SLOT_W-1:0] slot;
    logic [ARG_W-1:0]  argument;
    logic [REL_W-1:0]  relation;
  } in_data_t;

  typedef struct packed {
    logic [2:0]       pad;
    logic             ok;
    logic [ID_W-1:0]  out_value;
    logic [REL_W-1:0] out_relation;
  } out_data_t;

endpackage

// ===== rtl/tic_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tic_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_div
// Restoring divider, one quotient bit per cycle; done pulses with results.
// ----------------------------------------------------------------------------
module tic_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tic_pkg::ID_W-1:0] dividend_i,
  input  logic [tic_pkg::ID_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [tic_pkg::ID_W-1:0] quot_o,
  output logic [tic_pkg::ID_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(tic_pkg::ID_W);

  logic                     busy_q, done_q;
  logic [CW-1:0]            cnt_q;
  logic [tic_pkg::ID_W-1:0] r_q, q_q, d_q;
  logic [tic_pkg::ID_W:0]   trial;
  logic                     fits;

  assign trial = {r_q, q_q[tic_pkg::ID_W-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(tic_pkg::ID_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      q_q <= dividend_i;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= fits ? tic_pkg::ID_W'(trial - {1'b0, d_q}) : trial[tic_pkg::ID_W-1:0];
      q_q <= {q_q[tic_pkg::ID_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

// ===== rtl/tuple_id_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tuple_id_codec
// Mixed-radix tuple encoder and decoder over software-loaded domain tables.
// ----------------------------------------------------------------------------
// An encode term reads the header, then runs a binary search through the
// single read port of the record memory and passes the multiply/accumulate
// states E_MUL1, E_MUL2 and E_MUL3. A decode reads the predicate header and,
// per argument, runs the one-bit-per-cycle divider (skipped when the domain
// size is zero) and a binary search. Items are taken one at a time;
// a result waiting in the output register does not block acceptance.
// Memories have no reset; no clearing pass is run.
module tuple_id_codec (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // relation, argument, slot, term_relation, term_value, index_base,
  // domain_size, record_count, arity, zero pad
  input  logic [tic_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // req_type
  input  logic [2:0]                  s_axis_tuser_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // out_relation, out_value, ok, zero pad
  output logic [tic_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  // result_kind
  output logic                        m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  localparam int unsigned ID_W   = tic_pkg::ID_W;
  localparam int unsigned REL_W  = tic_pkg::REL_W;
  localparam int unsigned ARG_W  = tic_pkg::ARG_W;
  localparam int unsigned SLOT_W = tic_pkg::SLOT_W;
  localparam int unsigned CNT_W  = tic_pkg::CNT_W;
  localparam int unsigned AR_W   = tic_pkg::AR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] E_HDR  = 4'd1;
  localparam logic [3:0] E_RD   = 4'd2;
  localparam logic [3:0] E_CMP  = 4'd3;
  localparam logic [3:0] E_MUL1 = 4'd4;
  localparam logic [3:0] E_MUL2 = 4'd5;
  localparam logic [3:0] E_MUL3 = 4'd6;
  localparam logic [3:0] E_FIN  = 4'd7;
  localparam logic [3:0] D_HDR  = 4'd8;
  localparam logic [3:0] D_ARG  = 4'd9;
  localparam logic [3:0] D_ARGW = 4'd10;
  localparam logic [3:0] D_DIV  = 4'd11;
  localparam logic [3:0] D_RD   = 4'd12;
  localparam logic [3:0] D_CMP  = 4'd13;
  localparam logic [3:0] D_KEY  = 4'd14;

  function automatic logic [AR_W-1:0] clamp_ar(input logic [AR_W-1:0] a);
    return (a > AR_W'(tic_pkg::MAX_ARITY)) ? AR_W'(tic_pkg::MAX_ARITY) : a;
  endfunction

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c);
    return (c > CNT_W'(tic_pkg::SLOTS)) ? CNT_W'(tic_pkg::SLOTS) : c;
  endfunction

  tic_pkg::in_data_t  in_w;
  tic_pkg::out_data_t out_w;
  tic_pkg::req_e      req_w;
  logic               s_acc;

  logic [3:0]              state_q, state_d;
  logic [REL_W-1:0]        rel_q, rel_d, tr_q, tr_d;
  logic [ID_W-1:0]         tv_q, tv_d;
  logic                    last_q, last_d;
  logic [AR_W-1:0]         ar_q, ar_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [ID_W-1:0]         size_q, size_d;
  logic signed [CNT_W:0]   lo_q, lo_d, hi_q, hi_d;
  logic [SLOT_W-1:0]       mid_q, mid_d, ans_q, ans_d;
  logic [ID_W-1:0]         digit_q, digit_d, rem_q, rem_d, prod_q, prod_d;
  logic [ARG_W-1:0]        idx_q, idx_d;
  logic [ID_W-1:0]         sum_q, sum_d, fac_q, fac_d;
  logic [ARG_W-1:0]        pos_q, pos_d;
  logic                    efail_q, efail_d, fail_q, fail_d;

  logic                    m_valid_q;
  logic                    m_kind_q, m_last_q;
  tic_pkg::out_data_t      m_data_q;

  logic                    emit, e_kind, e_ok, e_last;
  logic [REL_W-1:0]        e_rel;
  logic [ID_W-1:0]         e_val;
  logic                    out_free;

  logic                    rec_we, rec_re, arg_we, arg_re, relh_we;
  logic [tic_pkg::REC_AW-1:0]  rec_raddr;
  logic [tic_pkg::HDR_AW-1:0]  arg_raddr;
  logic [tic_pkg::REC_DW-1:0]  rec_rdata;
  logic [tic_pkg::ARG_DW-1:0]  arg_rdata;
  logic [tic_pkg::RELH_DW-1:0] relh_rdata;

  logic                    div_start, div_done;
  logic [ID_W-1:0]         div_quot, div_rem;

  logic [CNT_W:0]          mid_sum;
  logic [SLOT_W-1:0]       mid_w;
  logic [REL_W-1:0]        rr_w;
  logic [ID_W-1:0]         rv_w, base_w;
  logic                    key_eq, key_lt;
  logic [AR_W-1:0]         pos_inc, idx_inc;
  logic                    pos_fail;
  logic [ID_W-1:0]         mul_b;
  logic [2*ID_W-1:0]       mul_full;

  assign in_w            = tic_pkg::in_data_t'(s_axis_tdata_i);
  assign req_w           = tic_pkg::req_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign mid_sum  = (CNT_W+1)'(lo_q + hi_q);
  assign mid_w    = mid_sum[SLOT_W:1];
  assign rr_w     = rec_rdata[tic_pkg::REC_DW-1 -: REL_W];
  assign rv_w     = rec_rdata[2*ID_W-1 -: ID_W];
  assign base_w   = rec_rdata[ID_W-1:0];
  assign key_eq   = (tr_q == rr_w) && ((tr_q != '0) || (tv_q == rv_w));
  assign key_lt   = (tr_q < rr_w) || ((tr_q == rr_w) && (tr_q == '0) && (tv_q < rv_w));
  assign pos_inc  = {1'b0, pos_q} + 3'd1;
  assign idx_inc  = {1'b0, idx_q} + 3'd1;
  assign pos_fail = last_q ? (pos_inc != ar_q) : (pos_inc >= ar_q);
  assign mul_b    = (state_q == E_MUL1) ? digit_q : size_q;
  assign mul_full = fac_q * mul_b;
  assign out_free = !m_valid_q || m_axis_tready_i;

  assign rec_we    = s_acc && (req_w == tic_pkg::REQ_REC);
  assign arg_we    = s_acc && (req_w == tic_pkg::REQ_ARG);
  assign relh_we   = s_acc && (req_w == tic_pkg::REQ_REL);
  assign arg_re    = s_acc || (state_q == D_ARG);
  assign arg_raddr = (state_q == D_ARG) ? {rel_q, idx_q} : {in_w.relation, pos_q};
  assign div_start = (state_q == D_ARGW) && (arg_rdata[tic_pkg::ARG_DW-1 -: ID_W] != '0);

  always_comb begin
    state_d = state_q;  rel_d = rel_q;   tr_d = tr_q;     tv_d = tv_q;
    last_d = last_q;    ar_d = ar_q;     cnt_d = cnt_q;   size_d = size_q;
    lo_d = lo_q;        hi_d = hi_q;     mid_d = mid_q;   ans_d = ans_q;
    digit_d = digit_q;  rem_d = rem_q;   prod_d = prod_q; idx_d = idx_q;
    sum_d = sum_q;      fac_d = fac_q;   pos_d = pos_q;
    efail_d = efail_q;  fail_d = fail_q;
    rec_re = 1'b0;      rec_raddr = {rel_q, pos_q, mid_w};
    emit = 1'b0;        e_kind = tic_pkg::KIND_DEC; e_rel = '0; e_val = '0;
    e_ok = 1'b0;        e_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          rel_d  = in_w.relation;
          tr_d   = in_w.term_relation;
          tv_d   = in_w.term_value;
          last_d = s_axis_tlast_i;
          fail_d = 1'b0;
          case (req_w)
            tic_pkg::REQ_ENC: state_d = E_HDR;
            tic_pkg::REQ_DEC: state_d = D_HDR;
            default: ;
          endcase
        end
      end
      E_HDR: begin
        ar_d   = clamp_ar(relh_rdata[tic_pkg::RELH_DW-1 -: AR_W]);
        cnt_d  = clamp_cnt(arg_rdata[CNT_W-1:0]);
        size_d = arg_rdata[tic_pkg::ARG_DW-1 -: ID_W];
        if ({1'b0, pos_q} >= clamp_ar(relh_rdata[tic_pkg::RELH_DW-1 -: AR_W])) begin
          fail_d  = 1'b1;
          state_d = E_FIN;
        end else begin
          lo_d    = '0;
          hi_d    = $signed({1'b0, clamp_cnt(arg_rdata[CNT_W-1:0])}) - 8'sd1;
          state_d = E_RD;
        end
      end
      E_RD: begin
        if (lo_q <= hi_q) begin
          rec_re  = 1'b1;
          mid_d   = mid_w;
          state_d = E_CMP;
        end else begin
          fail_d  = 1'b1;
          state_d = E_FIN;
        end
      end
      E_CMP: begin
        if (key_eq) begin
          digit_d = (tr_q == '0) ? base_w : base_w + tv_q;
          state_d = E_MUL1;
        end else begin
          if (key_lt) hi_d = $signed({2'b00, mid_q}) - 8'sd1;
          else        lo_d = $signed({2'b00, mid_q}) + 8'sd1;
          state_d = E_RD;
        end
      end
      E_MUL1: begin
        prod_d  = mul_full[ID_W-1:0];
        state_d = E_MUL2;
      end
      E_MUL2: begin
        sum_d   = sum_q + prod_q;
        prod_d  = mul_full[ID_W-1:0];
        state_d = E_MUL3;
      end
      E_MUL3: begin
        fac_d   = prod_q;
        state_d = E_FIN;
      end
      E_FIN: begin
        if (last_q) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = tic_pkg::KIND_ENC;
            e_ok    = !(efail_q || fail_q || pos_fail);
            e_val   = e_ok ? sum_q : '0;
            e_last  = 1'b1;
            sum_d   = '0;
            fac_d   = ID_W'(1);
            pos_d   = '0;
            efail_d = 1'b0;
            state_d = S_IDLE;
          end
        end else begin
          efail_d = efail_q || fail_q || pos_fail;
          pos_d   = (pos_q == '1) ? pos_q : pos_inc[ARG_W-1:0];
          state_d = S_IDLE;
        end
      end
      D_HDR: begin
        ar_d = clamp_ar(relh_rdata[tic_pkg::RELH_DW-1 -: AR_W]);
        if (out_free) begin
          emit    = 1'b1;
          e_val   = relh_rdata[ID_W-1:0];
          e_ok    = 1'b1;
          e_last  = (clamp_ar(relh_rdata[tic_pkg::RELH_DW-1 -: AR_W]) == '0);
          rem_d   = tv_q;
          idx_d   = '0;
          state_d = e_last ? S_IDLE : D_ARG;
        end
      end
      D_ARG: state_d = D_ARGW;
      D_ARGW: begin
        cnt_d = clamp_cnt(arg_rdata[CNT_W-1:0]);
        lo_d  = '0;
        hi_d  = $signed({1'b0, clamp_cnt(arg_rdata[CNT_W-1:0])}) - 8'sd1;
        ans_d = '0;
        if (div_start) begin
          state_d = D_DIV;
        end else begin
          digit_d = rem_q;
          rem_d   = '0;
          state_d = D_RD;
        end
      end
      D_DIV: begin
        if (div_done) begin
          digit_d = div_rem;
          rem_d   = div_quot;
          state_d = D_RD;
        end
      end
      D_RD: begin
        rec_re = 1'b1;
        if (lo_q <= hi_q) begin
          mid_d   = mid_w;
          state_d = D_CMP;
        end else begin
          rec_raddr = {rel_q, idx_q, ans_q};
          state_d   = D_KEY;
        end
        if (lo_q <= hi_q) rec_raddr = {rel_q, idx_q, mid_w};
      end
      D_CMP: begin
        if (base_w <= digit_q) begin
          ans_d = mid_q;
          lo_d  = $signed({2'b00, mid_q}) + 8'sd1;
        end else begin
          hi_d  = $signed({2'b00, mid_q}) - 8'sd1;
        end
        state_d = D_RD;
      end
      D_KEY: begin
        if (out_free) begin
          emit   = 1'b1;
          e_last = (idx_inc == ar_q);
          if (cnt_q != '0) begin
            e_ok  = 1'b1;
            e_rel = rr_w;
            e_val = (rr_w == '0) ? rv_w : digit_q - base_w;
          end
          idx_d   = idx_q + 1'b1;
          state_d = e_last ? S_IDLE : D_ARG;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      fac_q     <= ID_W'(1);
      pos_q     <= '0;
      efail_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      fac_q   <= fac_d;
      pos_q   <= pos_d;
      efail_q <= efail_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;     tr_q <= tr_d;       tv_q <= tv_d;       last_q <= last_d;
    ar_q <= ar_d;       cnt_q <= cnt_d;     size_q <= size_d;
    lo_q <= lo_d;       hi_q <= hi_d;       mid_q <= mid_d;     ans_q <= ans_d;
    digit_q <= digit_d; rem_q <= rem_d;     prod_q <= prod_d;   idx_q <= idx_d;
    fail_q <= fail_d;
    if (emit) begin
      m_kind_q              <= e_kind;
      m_last_q              <= e_last;
      m_data_q.pad          <= '0;
      m_data_q.ok           <= e_ok;
      m_data_q.out_value    <= e_val;
      m_data_q.out_relation <= e_rel;
    end
  end

  assign out_w           = m_data_q;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_w;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

  tic_ram #(
    .Width (tic_pkg::REC_DW),
    .Depth (tic_pkg::RELATIONS * tic_pkg::MAX_ARITY * tic_pkg::SLOTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i ({in_w.relation, in_w.argument, in_w.slot}),
    .wdata_i ({in_w.term_relation, in_w.term_value, in_w.index_base}),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  tic_ram #(
    .Width (tic_pkg::ARG_DW),
    .Depth (tic_pkg::RELATIONS * tic_pkg::MAX_ARITY)
  ) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (arg_we),
    .waddr_i ({in_w.relation, in_w.argument}),
    .wdata_i ({in_w.domain_size, in_w.record_count}),
    .re_i    (arg_re),
    .raddr_i (arg_raddr),
    .rdata_o (arg_rdata)
  );

  tic_ram #(
    .Width (tic_pkg::RELH_DW),
    .Depth (tic_pkg::RELATIONS)
  ) u_rel_ram (
    .clk_i   (clk_i),
    .we_i    (relh_we),
    .waddr_i (in_w.relation),
    .wdata_i ({in_w.arity, in_w.term_value}),
    .re_i    (s_acc),
    .raddr_i (in_w.relation),
    .rdata_o (relh_rdata)
  );

  tic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (arg_rdata[tic_pkg::ARG_DW-1 -: ID_W]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

endmodule

// ===== rtl/tic_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_checker
// Port-level checks of the tuple id codec result stream.
// ----------------------------------------------------------------------------
module tic_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid_i,
  input logic                       m_axis_tready_i,
  input logic [tic_pkg::OUT_DW-1:0] m_axis_tdata_i,
  input logic                       m_axis_tuser_i,
  input logic                       m_axis_tlast_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  a_enc_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i == tic_pkg::KIND_ENC)
      |-> m_axis_tlast_i && (m_axis_tdata_i[3:0] == 4'd0))
    else $error("encoded id not a lone atom-kind transaction");

  a_enc_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (m_axis_tuser_i == tic_pkg::KIND_ENC) && !m_axis_tdata_i[36]
      |-> (m_axis_tdata_i[35:4] == 32'd0))
    else $error("failed encode carries a non-zero id");

endmodule

bind tuple_id_codec tic_checker u_tic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
